@@ rtl/gnss_window_sequencer_defines.svh @@
// Assertion macros shared by the radio-sharing sequencer.
`ifndef GNSS_WINDOW_SEQUENCER_DEFINES_SVH
`define GNSS_WINDOW_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GWS_CHECK_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gws: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define GWS_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gws: next-cycle check failed");

`endif

@@ rtl/gws_pkg.sv @@
// Types, constants and the phase walk function of the radio-sharing sequencer.
package gws_pkg;

    localparam int LEN_W      = 16;
    localparam int MAXA_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 8;
    localparam int WALK_STEPS = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACQUIRE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXATT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REARM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 3'd5;

    localparam logic [LEN_W-1:0]  SETTLE_RST  = 16'd30;
    localparam logic [LEN_W-1:0]  ACQUIRE_RST = 16'd120;
    localparam logic [LEN_W-1:0]  RETRY_RST   = 16'd60;
    localparam logic [MAXA_W-1:0] MAXATT_RST  = 8'd0;
    localparam logic [LEN_W-1:0]  REARM_RST   = 16'd600;

    typedef enum logic [2:0] {
        PH_INERT = 3'd0,
        PH_INIT  = 3'd1,
        PH_ACQ   = 3'd2,
        PH_POST  = 3'd3,
        PH_COOL  = 3'd4,
        PH_REARM = 3'd5,
        PH_FIXED = 3'd6
    } phase_t;

    // Where the timer value of a phase comes from during one tick.
    typedef enum logic [1:0] {
        TMR_ZERO,
        TMR_ONE,
        TMR_HOLD,
        TMR_INC
    } tmr_src_t;

    // Where the attempt count comes from during one tick.
    typedef enum logic [1:0] {
        ATT_HOLD,
        ATT_INC,
        ATT_ZERO,
        ATT_ONE
    } att_src_t;

    typedef struct packed {
        logic [LEN_W-1:0]  settle;
        logic [LEN_W-1:0]  acquire;
        logic [LEN_W-1:0]  retry;
        logic [MAXA_W-1:0] max_attempts;
        logic [LEN_W-1:0]  rearm;
    } cfg_t;

    typedef struct packed {
        logic settle_zero;
        logic settle_le1;
        logic acquire_zero;
        logic acquire_le1;
        logic retry_zero;
        logic retry_le1;
        logic rearm_zero;
        logic rearm_le1;
        logic exp_now;
        logic exp_after;
        logic ge_hold;
        logic ge_inc;
        logic ge_one;
    } gws_flags_t;

    typedef struct packed {
        phase_t   phase;
        tmr_src_t tmr;
        att_src_t att;
        logic     fixed;
        logic     consumed;
        logic     started;
        logic     done;
    } walk_t;

    // One step of the phase walk within a tick. Timer and attempt values are
    // carried as source codes so that every decision here is a narrow one.
    function automatic walk_t gws_walk_step(walk_t s, gws_flags_t f, logic lte, logic fix);
        walk_t r;
        logic  len_zero;
        logic  len_le1;
        logic  expired;
        logic  leave;
        logic  ge;
        r        = s;
        len_zero = 1'b0;
        len_le1  = 1'b0;
        expired  = 1'b0;
        leave    = 1'b0;
        ge       = 1'b0;
        if (!s.done && (s.phase >= PH_INIT) && (s.phase <= PH_REARM))
        begin
            unique case (s.phase) inside
                PH_ACQ:
                begin
                    len_zero = f.acquire_zero;
                    len_le1  = f.acquire_le1;
                end
                PH_COOL:
                begin
                    len_zero = f.retry_zero;
                    len_le1  = f.retry_le1;
                end
                PH_REARM:
                begin
                    len_zero = f.rearm_zero;
                    len_le1  = f.rearm_le1;
                end
                default:
                begin
                    len_zero = f.settle_zero;
                    len_le1  = f.settle_le1;
                end
            endcase
            case (s.tmr)
                TMR_ZERO: expired = len_zero;
                TMR_ONE:  expired = len_le1;
                TMR_HOLD: expired = f.exp_now;
                default:  expired = f.exp_after;
            endcase
            case (s.att)
                ATT_HOLD: ge = f.ge_hold;
                ATT_INC:  ge = f.ge_inc;
                ATT_ONE:  ge = f.ge_one;
                default:  ge = 1'b0;
            endcase

            if (expired)
            begin
                leave = 1'b1;
            end
            else if (s.consumed)
            begin
                r.done = 1'b1;
            end
            else if (((s.phase == PH_INIT) || (s.phase == PH_POST)) && lte)
            begin
                leave = 1'b1;
            end
            else if ((s.phase == PH_ACQ) && fix)
            begin
                r.fixed = 1'b1;
                leave   = 1'b1;
            end
            else
            begin
                r.consumed = 1'b1;
                r.tmr      = (s.tmr == TMR_ZERO) ? TMR_ONE : TMR_INC;
            end

            if (leave)
            begin
                if (s.phase == PH_ACQ)
                begin
                    r.phase = PH_POST;
                    r.tmr   = TMR_ZERO;
                end
                else if (s.phase == PH_POST)
                begin
                    if (r.fixed)
                    begin
                        r.phase = PH_FIXED;
                    end
                    else if (!ge)
                    begin
                        r.phase = PH_COOL;
                    end
                    else
                    begin
                        r.phase = PH_REARM;
                    end
                    r.tmr = TMR_ZERO;
                end
                else if (s.started)
                begin
                    r.done = 1'b1;
                end
                else if (s.phase == PH_REARM)
                begin
                    r.att     = ATT_ONE;
                    r.started = 1'b1;
                    r.phase   = PH_ACQ;
                    r.tmr     = TMR_ZERO;
                end
                else if (ge)
                begin
                    r.phase = PH_REARM;
                    r.tmr   = TMR_ZERO;
                end
                else
                begin
                    r.att     = (s.att == ATT_ZERO) ? ATT_ONE : ATT_INC;
                    r.started = 1'b1;
                    r.phase   = PH_ACQ;
                    r.tmr     = TMR_ZERO;
                end
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/gws_core.sv @@
// Next-state logic of the sequencer for one tick, including chained phase changes.
module gws_core
    import gws_pkg::*;
#(
    parameter int TIMER_BITS   = 16,
    parameter int ATTEMPT_BITS = 8
)
(
    input  phase_t                  phase,
    input  logic [TIMER_BITS-1:0]   timer,
    input  logic [ATTEMPT_BITS-1:0] attempt,
    input  logic                    fixed,
    input  cfg_t                    cfg,
    input  logic                    lte,
    input  logic                    fix,
    input  logic                    stop,
    output phase_t                  phase_next,
    output logic [TIMER_BITS-1:0]   timer_next,
    output logic [ATTEMPT_BITS-1:0] attempt_next,
    output logic                    fixed_next
);

    localparam int TCMP_W = (TIMER_BITS + 1 > LEN_W) ? TIMER_BITS + 1 : LEN_W;
    localparam int ACMP_W = (ATTEMPT_BITS > MAXA_W) ? ATTEMPT_BITS : MAXA_W;

    logic [LEN_W-1:0]        cur_len;
    logic [TCMP_W-1:0]       t_ext;
    logic [TCMP_W-1:0]       t_inc_ext;
    logic [TCMP_W-1:0]       t_max_ext;
    logic [TCMP_W-1:0]       len_ext;
    logic [TIMER_BITS-1:0]   timer_inc;
    logic [ATTEMPT_BITS-1:0] attempt_inc;
    logic [ACMP_W-1:0]       a_ext;
    logic [ACMP_W-1:0]       a_inc_ext;
    logic [ACMP_W-1:0]       max_ext;
    logic                    max_nz;
    gws_flags_t              flags;
    walk_t                   walk [WALK_STEPS+1];
    walk_t                   last;

    always_comb
    begin
        unique case (phase) inside
            PH_ACQ:   cur_len = cfg.acquire;
            PH_COOL:  cur_len = cfg.retry;
            PH_REARM: cur_len = cfg.rearm;
            default:  cur_len = cfg.settle;
        endcase
    end

    assign t_ext       = TCMP_W'(timer);
    assign t_inc_ext   = t_ext + TCMP_W'(1);
    assign t_max_ext   = TCMP_W'({TIMER_BITS{1'b1}});
    assign len_ext     = TCMP_W'(cur_len);
    assign timer_inc   = t_inc_ext[TIMER_BITS-1:0];
    assign attempt_inc = (&attempt) ? attempt : attempt + ATTEMPT_BITS'(1);
    assign a_ext       = ACMP_W'(attempt);
    assign a_inc_ext   = ACMP_W'(attempt_inc);
    assign max_ext     = ACMP_W'(cfg.max_attempts);
    assign max_nz      = |cfg.max_attempts;

    always_comb
    begin
        flags.settle_zero  = (cfg.settle == '0);
        flags.settle_le1   = (cfg.settle[LEN_W-1:1] == '0);
        flags.acquire_zero = (cfg.acquire == '0);
        flags.acquire_le1  = (cfg.acquire[LEN_W-1:1] == '0);
        flags.retry_zero   = (cfg.retry == '0);
        flags.retry_le1    = (cfg.retry[LEN_W-1:1] == '0);
        flags.rearm_zero   = (cfg.rearm == '0);
        flags.rearm_le1    = (cfg.rearm[LEN_W-1:1] == '0);
        flags.exp_now      = (t_ext >= len_ext) || (t_ext == t_max_ext);
        flags.exp_after    = (t_inc_ext >= len_ext) || (t_inc_ext == t_max_ext);
        flags.ge_hold      = max_nz && (a_ext >= max_ext);
        flags.ge_inc       = max_nz && (a_inc_ext >= max_ext);
        flags.ge_one       = (cfg.max_attempts == MAXA_W'(1));
    end

    // A stop in a running phase drops to inert before any other decision.
    always_comb
    begin
        walk[0].phase    = phase;
        walk[0].tmr      = TMR_HOLD;
        walk[0].att      = ATT_HOLD;
        walk[0].fixed    = fixed;
        walk[0].consumed = 1'b0;
        walk[0].started  = 1'b0;
        walk[0].done     = 1'b0;
        if (stop && (phase >= PH_INIT) && (phase <= PH_REARM))
        begin
            walk[0].phase = PH_INERT;
            walk[0].tmr   = TMR_ZERO;
        end
        for (int i = 0; i < WALK_STEPS; i++)
        begin
            walk[i+1] = gws_walk_step(walk[i], flags, lte, fix);
        end
    end

    assign last       = walk[WALK_STEPS];
    assign phase_next = last.phase;
    assign fixed_next = last.fixed;

    always_comb
    begin
        case (last.tmr)
            TMR_ZERO: timer_next = '0;
            TMR_ONE:  timer_next = TIMER_BITS'(1);
            TMR_HOLD: timer_next = timer;
            default:  timer_next = timer_inc;
        endcase
        case (last.att)
            ATT_HOLD: attempt_next = attempt;
            ATT_INC:  attempt_next = attempt_inc;
            ATT_ZERO: attempt_next = '0;
            default:  attempt_next = ATTEMPT_BITS'(1);
        endcase
    end

endmodule

@@ rtl/gnss_window_sequencer.sv @@
// Top level of the radio-sharing sequencer: handshakes, registers and configuration.
//
//  Channel   Direction  Contents
//  s_axis    in         one tick: lte_connected, fix_present, stop_request
//  m_axis    out        one status per tick: radio_to_gnss, phase, attempt_count, fix_acquired
//  cfg       in         register writes, no read-back
//
// Each tick transaction is registered in the input register, evaluated combinationally,
// and its status lands in the output register when the tick advances. One tick is accepted
// every cycle unless the output stalls; the phase, timer and attempt registers close the loop.
// A stall on the output side holds the status and lets one further tick wait in the input
// register before tready falls. Reset leaves the block inert with default lengths.
`include "gnss_window_sequencer_defines.svh"

module gnss_window_sequencer
    import gws_pkg::*;
#(
    parameter int TIMER_BITS   = 16,
    parameter int ATTEMPT_BITS = 8
)
(
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           s_axis_tvalid,
    output logic                                           s_axis_tready,
    // lte_connected, fix_present, stop_request, zero fill
    input  logic [IN_DATA_W-1:0]                           s_axis_tdata,
    output logic                                           m_axis_tvalid,
    input  logic                                           m_axis_tready,
    // radio_to_gnss, phase, attempt_count, fix_acquired, zero fill
    output logic [(((5 + ATTEMPT_BITS) + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input  logic                                           cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]                           cfg_index,
    input  logic [CFG_DATA_W-1:0]                          cfg_data
);

    localparam int OUT_BITS   = 5 + ATTEMPT_BITS;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    cfg_t                    cfg_reg;
    cfg_t                    cfg_next;
    phase_t                  phase_reg;
    phase_t                  phase_next;
    logic [TIMER_BITS-1:0]   timer_reg;
    logic [TIMER_BITS-1:0]   timer_next;
    logic [ATTEMPT_BITS-1:0] attempt_reg;
    logic [ATTEMPT_BITS-1:0] attempt_next;
    logic                    fixed_reg;
    logic                    fixed_next;

    phase_t                  core_phase;
    logic [TIMER_BITS-1:0]   core_timer;
    logic [ATTEMPT_BITS-1:0] core_attempt;
    logic                    core_fixed;

    logic                    in_valid_reg;
    logic                    in_valid_next;
    logic                    lte_reg;
    logic                    fix_reg;
    logic                    stop_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [OUT_DATA_W-1:0]   out_data_reg;
    logic [OUT_DATA_W-1:0]   out_data_next;
    logic                    in_take;
    logic                    advance;
    logic                    post_or_idle;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign post_or_idle  = (phase_reg == PH_POST) || (phase_reg == PH_FIXED) ||
                           (phase_reg == PH_INERT);

    gws_core #(
        .TIMER_BITS   (TIMER_BITS),
        .ATTEMPT_BITS (ATTEMPT_BITS)
    ) u_core (
        .phase        (phase_reg),
        .timer        (timer_reg),
        .attempt      (attempt_reg),
        .fixed        (fixed_reg),
        .cfg          (cfg_reg),
        .lte          (lte_reg),
        .fix          (fix_reg),
        .stop         (stop_reg),
        .phase_next   (core_phase),
        .timer_next   (core_timer),
        .attempt_next (core_attempt),
        .fixed_next   (core_fixed)
    );

    always_comb
    begin
        cfg_next       = cfg_reg;
        phase_next     = phase_reg;
        timer_next     = timer_reg;
        attempt_next   = attempt_reg;
        fixed_next     = fixed_reg;
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;

        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (advance)
        begin
            phase_next   = core_phase;
            timer_next   = core_timer;
            attempt_next = core_attempt;
            fixed_next   = core_fixed;
        end

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SETTLE:  cfg_next.settle       = cfg_data[LEN_W-1:0];
                CFG_ACQUIRE: cfg_next.acquire      = cfg_data[LEN_W-1:0];
                CFG_RETRY:   cfg_next.retry        = cfg_data[LEN_W-1:0];
                CFG_MAXATT:  cfg_next.max_attempts = cfg_data[MAXA_W-1:0];
                CFG_REARM:   cfg_next.rearm        = cfg_data[LEN_W-1:0];
                CFG_POLICY:
                begin
                    if (!cfg_data[0])
                    begin
                        phase_next   = PH_INERT;
                        timer_next   = '0;
                        attempt_next = '0;
                        fixed_next   = 1'b0;
                    end
                    else if ((phase_reg == PH_INERT) || (phase_reg == PH_FIXED))
                    begin
                        phase_next   = PH_INIT;
                        timer_next   = '0;
                        attempt_next = '0;
                        fixed_next   = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        out_data_next                      = '0;
        out_data_next[0]                   = (core_phase == PH_ACQ);
        out_data_next[3:1]                 = core_phase;
        out_data_next[4 +: ATTEMPT_BITS]   = core_attempt;
        out_data_next[4 + ATTEMPT_BITS]    = core_fixed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle       <= SETTLE_RST;
            cfg_reg.acquire      <= ACQUIRE_RST;
            cfg_reg.retry        <= RETRY_RST;
            cfg_reg.max_attempts <= MAXATT_RST;
            cfg_reg.rearm        <= REARM_RST;
            phase_reg            <= PH_INERT;
            timer_reg            <= '0;
            attempt_reg          <= '0;
            fixed_reg            <= 1'b0;
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            phase_reg     <= phase_next;
            timer_reg     <= timer_next;
            attempt_reg   <= attempt_next;
            fixed_reg     <= fixed_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            lte_reg  <= s_axis_tdata[0];
            fix_reg  <= s_axis_tdata[1];
            stop_reg <= s_axis_tdata[2];
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    `GWS_CHECK_IMP(a_fix_ends_run, fixed_reg, post_or_idle)
    `GWS_CHECK_IMP(a_window_counted, phase_reg == PH_ACQ, attempt_reg != '0)
    `GWS_CHECK_IMP(a_idle_timer_clear, (phase_reg == PH_INERT) || (phase_reg == PH_FIXED), timer_reg == '0)
    `GWS_CHECK_NEXT(a_result_follows, advance, out_valid_reg)

endmodule
